// ===== hdl/tva_pkg.sv =====
`default_nettype none
package tva_pkg;

   // joint count and field widths
   localparam int JOINT_COUNT = 7;
   localparam int JOINT_W     = 3;
   localparam int TORQUE_W    = 16;
   localparam int VEL_W       = 24;
   localparam int DEADBAND_W  = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 24;
   localparam int WEIGHT_W    = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 56;

   // register indexes past the per-joint settings
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT = 3'd7;

   // fixed-point constants
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd62259;
   localparam logic [VEL_W-2:0]    VEL_MAG_MAX  = 23'h7FFFFF;
   localparam logic [VEL_W-1:0]    SNAP_LEVEL   = 24'd53;

   // per-joint settings word: deadband[55:40], gain[39:24], limit[23:0]
   typedef struct packed {
      logic [DEADBAND_W-1:0] deadband;
      logic [GAIN_W-1:0]     gain;
      logic [LIMIT_W-1:0]    limit;
   } joint_cfg_type;

endpackage
`default_nettype wire

// ===== hdl/tva_if.sv =====
`default_nettype none
interface tva_req_if;
   import tva_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [JOINT_W-1:0]         joint_number;
   logic signed [TORQUE_W-1:0] torque_sample;
   modport source (output valid, joint_number, torque_sample, input ready);
   modport sink (input valid, joint_number, torque_sample, output ready);
endinterface

interface tva_rsp_if;
   import tva_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [JOINT_W-1:0]      joint_id;
   logic signed [VEL_W-1:0] velocity_command;
   modport source (output valid, joint_id, velocity_command, input ready);
   modport sink (input valid, joint_id, velocity_command, output ready);
endinterface

interface tva_csr_if;
   import tva_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tva_ram.sv =====
`default_nettype none
module tva_ram #(
   parameter int  WIDTH  = 24,
   parameter int  DEPTH  = 7,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== hdl/tva_cfg.sv =====
`default_nettype none
module tva_cfg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   tva_csr_if.sink                      csr,
   input  wire logic [2:0]              joint_sel,
   output tva_pkg::joint_cfg_type       joint_cfg,
   output logic [16:0]                  weight
);
   import tva_pkg::*;

   joint_cfg_type       settings_ff [JOINT_COUNT];
   logic [WEIGHT_W-1:0] weight_ff;

   assign csr.ready = 1'b1;

   // register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JOINT_COUNT; i++) begin
            settings_ff[i] <= '0;
         end
         weight_ff <= WEIGHT_RESET;
      end else if (csr.valid && csr.ready) begin
         if (csr.index < CSR_INDEX_W'(JOINT_COUNT)) begin
            settings_ff[csr.index] <= joint_cfg_type'(csr.data);
         end else if (csr.index == CSR_WEIGHT) begin
            weight_ff <= csr.data[WEIGHT_W-1:0];
         end
      end
   end

   // settings lookup for the joint in flight
   assign joint_cfg = (joint_sel < JOINT_W'(JOINT_COUNT)) ? settings_ff[joint_sel] : '0;

   // weights above one act as one
   assign weight = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;

endmodule
`default_nettype wire

// ===== hdl/torque_to_velocity_admittance.sv =====
`default_nettype none
// Torque-to-velocity admittance for up to seven joints. Each torque transaction
// names a joint; torque inside that joint's deadband gives zero, otherwise the
// excess times the gain (rounded, clamped to the speed limit, sign reversed) is
// blended with the joint's last command by the smoothing weight, rounded half
// up, and snapped to zero below 53 LSB. Joint numbers of 7 are dropped with no
// result. The settings lookup and previous-velocity memory read happen at
// acceptance; then S_MUL does the gain multiply, S_BLD1 and S_BLD2 the two
// blend multiplies, and S_FIN the rounding and write-back into the output
// register. The next item is accepted in the cycle after the write-back, so
// the block takes no new item while one is in flight. Write-back waits while
// the output register is full.
// The per-joint history lives in a small memory; seven valid bits make unwritten
// joints read as zero right after reset, so there is no clearing pass. The
// user must write registers only while the block is idle; this is not enforced.
module torque_to_velocity_admittance (
   input wire logic  clock,
   input wire logic  reset,
   tva_req_if.sink   req,
   tva_rsp_if.source rsp,
   tva_csr_if.sink   csr
);
   import tva_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_BLD1,
      S_BLD2,
      S_FIN
   } state_type;

   state_type                 state_ff;
   logic [JOINT_W-1:0]        joint_ff;
   logic                      neg_ff;
   logic                      pass_ff;
   logic [TORQUE_W:0]         excess_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [VEL_W-2:0]          limit_ff;
   logic signed [VEL_W-1:0]   vraw_ff;
   logic signed [VEL_W-1:0]   prev_ff;
   logic signed [41:0]        prod_ff;
   logic signed [42:0]        acc_ff;
   logic [JOINT_COUNT-1:0]    valid_ff;
   logic                      rsp_valid_ff;
   logic [JOINT_W-1:0]        rsp_joint_ff;
   logic signed [VEL_W-1:0]   rsp_vel_ff;

   joint_cfg_type             jcfg;
   logic [WEIGHT_W-1:0]       weight;
   logic [TORQUE_W:0]         mag;
   logic [VEL_W-2:0]          limit_eff;
   logic [32:0]               gprod;
   logic [33:0]               gsum;
   logic [VEL_W-2:0]          vmag;
   logic signed [VEL_W-1:0]   vraw;
   logic signed [WEIGHT_W:0]  wt_new;
   logic signed [WEIGHT_W:0]  wt_old;
   logic signed [41:0]        prod_new;
   logic signed [41:0]        prod_old;
   logic signed [42:0]        rsum;
   logic signed [26:0]        shifted;
   logic signed [VEL_W-1:0]   sat;
   logic signed [VEL_W-1:0]   result;
   logic [VEL_W-1:0]          ram_rdata;
   logic                      ram_we;
   logic                      accept;
   logic                      out_free;

   tva_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .joint_sel (req.joint_number),
      .joint_cfg (jcfg),
      .weight    (weight)
   );

   tva_ram #(.WIDTH(VEL_W), .DEPTH(JOINT_COUNT)) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (joint_ff),
      .wdata (result),
      .raddr (req.joint_number),
      .rdata (ram_rdata)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign ram_we    = (state_ff == S_FIN) && out_free;

   // torque magnitude, deadband excess and effective limit
   always_comb begin
      if (req.torque_sample[TORQUE_W-1]) begin
         mag = (TORQUE_W+1)'(0) - {1'b1, req.torque_sample};
      end else begin
         mag = {1'b0, req.torque_sample};
      end
      limit_eff = jcfg.limit[LIMIT_W-1] ? VEL_MAG_MAX : jcfg.limit[LIMIT_W-2:0];
   end

   // gain product, round half up to Q4.19, clamp, reverse sign
   always_comb begin
      gprod = excess_ff * gain_ff;
      gsum  = {1'b0, gprod} + 34'd1;
      if (!pass_ff) begin
         vmag = '0;
      end else if (gsum[33:1] > {10'd0, limit_ff}) begin
         vmag = limit_ff;
      end else begin
         vmag = gsum[VEL_W-1:1];
      end
      vraw = neg_ff ? (VEL_W'(0) - {1'b0, vmag}) : {1'b0, vmag};
   end

   // blend products and final rounding, saturation, snap
   always_comb begin
      wt_new   = $signed({1'b0, weight});
      wt_old   = $signed({1'b0, WEIGHT_ONE - weight});
      prod_new = vraw_ff * wt_new;
      prod_old = prev_ff * wt_old;
      rsum     = acc_ff + 43'sd32768;
      shifted  = 27'(rsum >>> 16);
      if (shifted > 27'sd8388607) begin
         sat = 24'sh7FFFFF;
      end else if (shifted < -27'sd8388608) begin
         sat = 24'sh800000;
      end else begin
         sat = shifted[VEL_W-1:0];
      end
      if ((sat > -$signed(SNAP_LEVEL)) && (sat < $signed(SNAP_LEVEL))) begin
         result = '0;
      end else begin
         result = sat;
      end
   end

   // sequencer, datapath registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register loads on write-back, clears when taken
         if (ram_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req.joint_number < JOINT_W'(JOINT_COUNT))) begin
                  state_ff  <= S_MUL;
                  joint_ff  <= req.joint_number;
                  neg_ff    <= !req.torque_sample[TORQUE_W-1] && (req.torque_sample != '0);
                  pass_ff   <= mag > {1'b0, jcfg.deadband};
                  excess_ff <= mag - {1'b0, jcfg.deadband};
                  gain_ff   <= jcfg.gain;
                  limit_ff  <= limit_eff;
               end
            end
            S_MUL: begin
               vraw_ff  <= vraw;
               prev_ff  <= valid_ff[joint_ff] ? ram_rdata : '0;
               state_ff <= S_BLD1;
            end
            S_BLD1: begin
               prod_ff  <= prod_new;
               state_ff <= S_BLD2;
            end
            S_BLD2: begin
               acc_ff   <= {prod_ff[41], prod_ff} + {prod_old[41], prod_old};
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (out_free) begin
                  valid_ff[joint_ff] <= 1'b1;
                  rsp_joint_ff       <= joint_ff;
                  rsp_vel_ff         <= result;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.joint_id         = rsp_joint_ff;
   assign rsp.velocity_command = rsp_vel_ff;

   // write-back lands in the output register with the same value
   a_wb_to_rsp: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_valid_ff && (rsp_vel_ff == $past(result))
                 && (rsp_joint_ff == $past(joint_ff)))
      else $error("write-back and response disagree");

   // a written joint is marked valid afterwards
   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(joint_ff)])
      else $error("history valid bit not set");

   // delivered velocities are snapped
   a_snap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_vel_ff == '0) || (rsp_vel_ff >= $signed(SNAP_LEVEL))
                       || (rsp_vel_ff <= -$signed(SNAP_LEVEL)))
      else $error("unsnapped velocity delivered");

   // only in-range joints are ever in flight
   a_joint_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (joint_ff < JOINT_W'(JOINT_COUNT)))
      else $error("out-of-range joint in flight");

endmodule
`default_nettype wire
